>>> rtl/core/lgcd_pkg.sv
// Shared widths, operation and command codes and controller states of the glyph compositor.
package lgcd_pkg;

	localparam int PAT_W      = 40;
	localparam int COL_W      = 4;
	localparam int ROW_W      = 1;
	localparam int SLOT_W     = 3;
	localparam int OP_W       = 2;
	localparam int CMD_W      = 2;
	localparam int RESULT_CAP = 40;
	localparam int CNT_W      = 6;

	localparam logic [OP_W-1:0] OP_DRAW   = 2'd0;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEFINE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FULL   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_SCAN,
		ST_LOOK,
		ST_PLACE,
		ST_CLEAR
	} state_t;

endpackage

>>> rtl/core/lgcd_item_if.sv
// Input channel of the glyph compositor: one draw, flush or clear word.
interface lgcd_item_if;
	logic                         valid;
	logic                         ready;
	logic [lgcd_pkg::OP_W-1:0]    operation;
	logic [lgcd_pkg::COL_W-1:0]   column;
	logic [lgcd_pkg::ROW_W-1:0]   cell_row;
	logic [lgcd_pkg::PAT_W-1:0]   glyph_bits;

	modport source (output valid, operation, column, cell_row, glyph_bits, input ready);
	modport sink   (input valid, operation, column, cell_row, glyph_bits, output ready);
endinterface

>>> rtl/core/lgcd_result_if.sv
// Output channel of the glyph compositor: one display command word.
interface lgcd_result_if;
	logic                         valid;
	logic                         ready;
	logic [lgcd_pkg::CMD_W-1:0]   command;
	logic [lgcd_pkg::SLOT_W-1:0]  slot;
	logic [lgcd_pkg::COL_W-1:0]   out_column;
	logic [lgcd_pkg::ROW_W-1:0]   out_row;
	logic [lgcd_pkg::PAT_W-1:0]   pattern;
	logic                         last;

	modport source (output valid, command, slot, out_column, out_row, pattern, last,
		input ready);
	modport sink   (input valid, command, slot, out_column, out_row, pattern, last,
		output ready);
endinterface

>>> rtl/core/lcd_glyph_compositor_dedup.sv
// A draw reads the cell memory, then writes the merged pattern back.
// A clear emits one clear command word; a flush visits each cell in turn and emits the
// result words of each active cell, all gated by the single cell memory port and the
// output register; one word is in work at a time.
// Reset clears the active and used flags at once; the cell memory needs no sweep,
// since an inactive cell reads as zero.
module lcd_glyph_compositor_dedup #(
	parameter int COLUMNS   = 16,
	parameter int ROWS_N    = 2,
	parameter int SLOTS     = 8,
	parameter int LINES     = 8,
	parameter int LINE_BITS = 5
) (
	input logic            clk,
	input logic            arst_n,
	lgcd_item_if.sink      item,
	lgcd_result_if.source  result
);
	import lgcd_pkg::*;

	localparam int CELLS   = COLUMNS * ROWS_N;
	localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int WCOL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int WROW_W  = (ROWS_N > 1) ? $clog2(ROWS_N) : 1;
	localparam int SIDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int GLYPH_W = LINES * LINE_BITS;
	localparam logic [PAT_W-1:0] GLYPH_MASK = ~({PAT_W{1'b1}} << GLYPH_W);

	state_t state_q, state_d;

	logic [PAT_W-1:0]  cell_mem [CELLS];
	logic [PAT_W-1:0]  rd_data_q;
	logic [CELLS-1:0]  active_q;
	logic [PAT_W-1:0]  glyph_q [SLOTS];
	logic [SLOTS-1:0]  used_q;

	logic [ADDR_W-1:0] c_q;
	logic [WCOL_W-1:0] wcol_q;
	logic [WROW_W-1:0] wrow_q;
	logic [CNT_W-1:0]  n_q;
	logic [SIDX_W-1:0] place_slot_q;
	logic [ADDR_W-1:0] draw_addr_q;
	logic [PAT_W-1:0]  draw_bits_q;

	logic              res_valid_q;
	logic [CMD_W-1:0]  res_cmd_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [COL_W-1:0]  res_col_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [PAT_W-1:0]  res_pat_q;
	logic              res_last_q;

	logic              accept, out_free, in_grid;
	logic [ADDR_W-1:0] draw_addr;
	logic              rd_en, draw_latch, flush_start, clear_go, mem_we, tbl_we, walk_adv;
	logic [ADDR_W-1:0] rd_addr;
	logic              emit, emit_last;
	logic [CMD_W-1:0]  emit_cmd;
	logic [SLOT_W-1:0] emit_slot;
	logic [COL_W-1:0]  emit_col;
	logic [ROW_W-1:0]  emit_row;
	logic [PAT_W-1:0]  emit_pat;
	logic              hit, free_found, more_active, cap_last, cell_last;
	logic [SIDX_W-1:0] hit_idx, free_idx;
	logic [CELLS-1:0]  above_mask;

	assign accept    = item.valid && item.ready;
	assign out_free  = !res_valid_q || result.ready;
	assign in_grid   = (int'(item.column) < COLUMNS) && (int'(item.cell_row) < ROWS_N);
	assign draw_addr = ADDR_W'(int'(item.cell_row) * COLUMNS + int'(item.column));

	assign item.ready = (state_q == ST_IDLE);

	// A flush result closes the item when no active cell lies beyond the current one or the result cap is reached.
	assign above_mask  = ({CELLS{1'b1}} << c_q) << 1;
	assign more_active = |(active_q & above_mask);
	assign cap_last    = (n_q == CNT_W'(RESULT_CAP - 1));
	assign cell_last   = !more_active || cap_last;

	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (used_q[s] && (glyph_q[s] == rd_data_q)) begin
				hit     = 1'b1;
				hit_idx = SIDX_W'(s);
			end
			if (!used_q[s]) begin
				free_found = 1'b1;
				free_idx   = SIDX_W'(s);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.operation)
						OP_DRAW:  state_d = in_grid ? ST_DRAW : ST_IDLE;
						OP_FLUSH: state_d = ST_SCAN;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_DRAW: state_d = ST_IDLE;
			ST_SCAN: begin
				if (active_q[c_q]) begin
					state_d = ST_LOOK;
				end else if (c_q == ADDR_W'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					if (emit_last) begin
						state_d = ST_IDLE;
					end else if (!hit && free_found) begin
						state_d = ST_PLACE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_PLACE: begin
				if (out_free) begin
					state_d = emit_last ? ST_IDLE : ST_SCAN;
				end
			end
			ST_CLEAR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = c_q;
		draw_latch  = 1'b0;
		flush_start = 1'b0;
		clear_go    = 1'b0;
		mem_we      = 1'b0;
		tbl_we      = 1'b0;
		walk_adv    = 1'b0;
		emit        = 1'b0;
		emit_cmd    = CMD_CLEAR;
		emit_slot   = '0;
		emit_col    = '0;
		emit_row    = '0;
		emit_pat    = '0;
		emit_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.operation)
						OP_DRAW: begin
							if (in_grid) begin
								rd_en      = 1'b1;
								rd_addr    = draw_addr;
								draw_latch = 1'b1;
							end
						end
						OP_FLUSH: flush_start = 1'b1;
						OP_CLEAR: clear_go = 1'b1;
						default: ;
					endcase
				end
			end
			ST_DRAW: mem_we = 1'b1;
			ST_SCAN: begin
				if (active_q[c_q]) begin
					rd_en = 1'b1;
				end else begin
					walk_adv = 1'b1;
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					emit = 1'b1;
					if (hit) begin
						emit_cmd  = CMD_PLACE;
						emit_slot = SLOT_W'(hit_idx);
						emit_col  = COL_W'(wcol_q);
						emit_row  = ROW_W'(wrow_q);
						emit_last = cell_last;
						walk_adv  = !cell_last;
					end else if (free_found) begin
						emit_cmd  = CMD_DEFINE;
						emit_slot = SLOT_W'(free_idx);
						emit_pat  = rd_data_q;
						emit_last = cap_last;
						tbl_we    = 1'b1;
					end else begin
						emit_cmd  = CMD_FULL;
						emit_col  = COL_W'(wcol_q);
						emit_row  = ROW_W'(wrow_q);
						emit_pat  = rd_data_q;
						emit_last = cell_last;
						walk_adv  = !cell_last;
					end
				end
			end
			ST_PLACE: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_cmd  = CMD_PLACE;
					emit_slot = SLOT_W'(place_slot_q);
					emit_col  = COL_W'(wcol_q);
					emit_row  = ROW_W'(wrow_q);
					emit_last = cell_last;
					walk_adv  = !cell_last;
				end
			end
			ST_CLEAR: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_cmd  = CMD_CLEAR;
					emit_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Cell memory: one port, registered read; an inactive cell is treated as blank.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[draw_addr_q] <= (active_q[draw_addr_q] ? rd_data_q : '0) | draw_bits_q;
		end
		if (rd_en) begin
			rd_data_q <= cell_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			glyph_q[free_idx] <= rd_data_q;
		end
		if (tbl_we) begin
			place_slot_q <= free_idx;
		end
		if (draw_latch) begin
			draw_addr_q <= draw_addr;
			draw_bits_q <= item.glyph_bits & GLYPH_MASK;
		end
		if (emit) begin
			res_cmd_q  <= emit_cmd;
			res_slot_q <= emit_slot;
			res_col_q  <= emit_col;
			res_row_q  <= emit_row;
			res_pat_q  <= emit_pat;
			res_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			used_q      <= '0;
			c_q         <= '0;
			wcol_q      <= '0;
			wrow_q      <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				active_q[draw_addr_q] <= 1'b1;
			end
			if (clear_go) begin
				active_q <= '0;
				used_q   <= '0;
			end
			if (tbl_we) begin
				used_q[free_idx] <= 1'b1;
			end
			if (flush_start) begin
				c_q    <= '0;
				wcol_q <= '0;
				wrow_q <= '0;
				n_q    <= '0;
			end else if (walk_adv) begin
				c_q <= c_q + 1'b1;
				if (wcol_q == WCOL_W'(COLUMNS - 1)) begin
					wcol_q <= '0;
					wrow_q <= wrow_q + 1'b1;
				end else begin
					wcol_q <= wcol_q + 1'b1;
				end
			end
			if (emit) begin
				n_q <= n_q + 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = res_valid_q;
	assign result.command    = res_cmd_q;
	assign result.slot       = res_slot_q;
	assign result.out_column = res_col_q;
	assign result.out_row    = res_row_q;
	assign result.pattern    = res_pat_q;
	assign result.last       = res_last_q;

	// A new glyph definition must always land in a slot that then reads as used.
	a_define_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |=> used_q[$past(free_idx)])
		else $error("defined slot not marked used");

	// The walk index never runs past the last cell while scanning.
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (int'(c_q) < CELLS))
		else $error("walk index beyond the screen");

	// Used slots are only released by a clear word.
	a_used_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_go |=> ($countones(used_q) >= $past($countones(used_q))))
		else $error("used slot released without a clear");

endmodule
